// File: rtl/core/arpc_pkg.sv
// shared types and constants of the arp cache responder
package arpc_pkg;

   // default table size
   localparam int DEFAULT_ENTRIES = 32;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_MY_IP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MY_MAC = 2'd1;

   // arp header values that a packet is checked against
   localparam logic [15:0] HW_TYPE_ETHER  = 16'h0001;
   localparam logic [15:0] TYPE_IP        = 16'h0800;
   localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
   localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
   localparam logic [15:0] OPCODE_REPLY   = 16'd2;

   // request payload
   typedef struct packed {
      logic        mode;
      logic [31:0] query_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
      logic [15:0] opcode;
      logic [15:0] hw_space;
      logic [15:0] proto_space;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
   } arpc_req_type;

   // response payload
   typedef struct packed {
      logic        hit;
      logic [47:0] resolved_mac;
      logic        frame_ok;
      logic        send_reply;
      logic [47:0] reply_target_mac;
      logic [31:0] reply_target_ip;
   } arpc_rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_OUT
   } arpc_state_type;

endpackage

// File: rtl/core/arpc_req_if.sv
// request channel interface of the arp cache responder
interface arpc_req_if;
   import arpc_pkg::*;

   logic         valid;
   logic         ready;
   arpc_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/arpc_rsp_if.sv
// response channel interface of the arp cache responder
interface arpc_rsp_if;
   import arpc_pkg::*;

   logic         valid;
   logic         ready;
   arpc_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/arpc_ram.sv
// generic single write port ram with registered read
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/arp_cache_responder_unit.sv
// ARP cache responder: a fully associative table of ENTRIES IPv4-to-MAC entries in
// most-recently-used order, held in one entry RAM (ip, mac, rank) with a single read
// and a single write port. A lookup (mode 0) or received ARP packet (mode 1) is taken
// one at a time: the RAM is swept once to search (its read data is registered), a
// decide state follows, and when an entry is hit or replaced a second sweep rewrites
// every rank, then the response is registered. No new request is taken while one is
// in the search, decide or rank sweep, and a response still held by a stalled sink
// holds the next one in its last state. A new request is taken as soon as the
// previous response sits in the output register. Valid bits are flip-flops cleared
// by reset; ranks read as their entry index until the first rank sweep has written
// the whole RAM, so no clearing pass is needed after reset. my_mac is the source
// address of the reply frame built downstream and is not kept here.
module arp_cache_responder_unit #(
   parameter int ENTRIES = arpc_pkg::DEFAULT_ENTRIES
) (
   input  logic                           clock,
   input  logic                           reset,
   arpc_req_if.sink                       req_if,
   arpc_rsp_if.source                     rsp_if,
   input  logic                           csr_we,
   input  logic [arpc_pkg::CSR_IDX_W-1:0] csr_idx,
   input  logic [arpc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import arpc_pkg::*;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = IDX_W + 1;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int RAM_W   = IP_W + MAC_W + IDX_W;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ENTRIES);

   // sequencer and control
   arpc_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               rank_init_ff, rank_init_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IP_W-1:0]    my_ip_ff, my_ip_in;

   // item and search results
   arpc_req_type       req_ff, req_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]   hit_rank_ff, hit_rank_in;
   logic [MAC_W-1:0]   hit_mac_ff, hit_mac_in;
   logic [IDX_W-1:0]   lru_idx_ff, lru_idx_in;
   logic [IDX_W-1:0]   lru_rank_ff, lru_rank_in;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   logic [IDX_W-1:0]   tgt_rank_ff, tgt_rank_in;
   logic               wr_ip_ff, wr_ip_in;
   logic               wr_mac_ff, wr_mac_in;
   arpc_rsp_type       res_ff, res_in;
   arpc_rsp_type       rsp_data_ff, rsp_data_in;

   // decision of the current item
   logic               dec_frame_ok;
   logic               dec_ours;
   logic               dec_upd;
   logic [IDX_W-1:0]   dec_tgt;
   logic [IDX_W-1:0]   dec_rank;
   logic               dec_wr_ip;
   logic               dec_wr_mac;
   arpc_rsp_type       dec_res;

   // control strobes
   logic               req_xfer;
   logic               issue;
   logic               sweep_done;
   logic               rsp_load;

   // entry ram
   logic               ram_we;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [RAM_W-1:0]   ram_wr_data;
   logic [RAM_W-1:0]   ram_rd_data;
   logic [IP_W-1:0]    rd_ip;
   logic [MAC_W-1:0]   rd_mac;
   logic [IDX_W-1:0]   rd_rank;
   logic [IDX_W-1:0]   rank_eff;
   logic [IDX_W-1:0]   new_rank;
   logic               at_tgt;

   arpc_ram #(
      .WIDTH (RAM_W),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pend_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // entry fields and effective rank
   assign rd_ip    = ram_rd_data[RAM_W-1 -: IP_W];
   assign rd_mac   = ram_rd_data[IDX_W +: MAC_W];
   assign rd_rank  = ram_rd_data[IDX_W-1:0];
   assign rank_eff = rank_init_ff ? rd_rank : pend_idx_ff;
   assign at_tgt   = (pend_idx_ff == tgt_ff);

   // move-to-front rank for the entry being rewritten
   always_comb begin
      if (at_tgt) begin
         new_rank = '0;
      end else if (rank_eff < tgt_rank_ff) begin
         new_rank = rank_eff + 1'b1;
      end else begin
         new_rank = rank_eff;
      end
   end

   assign ram_wr_data = {(at_tgt && wr_ip_ff) ? req_ff.query_ip : rd_ip,
                         (at_tgt && wr_mac_ff) ? req_ff.sender_mac : rd_mac,
                         new_rank};

   // handshake strobes
   assign req_xfer   = req_if.valid && req_if.ready;
   assign sweep_done = (cnt_ff == CNT_END) && !pend_ff;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_if.ready);

   // decision from search results
   always_comb begin
      dec_frame_ok = req_ff.mode
                     && (req_ff.hw_space == HW_TYPE_ETHER)
                     && (req_ff.proto_space == TYPE_IP)
                     && (req_ff.hw_len == HW_ADDR_LEN)
                     && (req_ff.proto_len == PROTO_ADDR_LEN);
      dec_ours   = (req_ff.target_ip == my_ip_ff);
      dec_res    = '0;
      dec_upd    = 1'b0;
      dec_tgt    = hit_idx_ff;
      dec_rank   = hit_rank_ff;
      dec_wr_ip  = 1'b0;
      dec_wr_mac = 1'b0;
      if (!req_ff.mode) begin
         // lookup
         if (hit_ff) begin
            dec_res.hit          = 1'b1;
            dec_res.resolved_mac = hit_mac_ff;
            dec_upd              = 1'b1;
         end
      end else if (dec_frame_ok) begin
         dec_res.frame_ok = 1'b1;
         if (hit_ff) begin
            // refresh cached sender
            dec_res.hit = 1'b1;
            dec_upd     = 1'b1;
            dec_wr_mac  = 1'b1;
         end else if (dec_ours) begin
            // replace least recent entry
            dec_upd    = 1'b1;
            dec_tgt    = lru_idx_ff;
            dec_rank   = lru_rank_ff;
            dec_wr_ip  = 1'b1;
            dec_wr_mac = 1'b1;
         end
         if (dec_ours && (req_ff.opcode != OPCODE_REPLY)) begin
            dec_res.send_reply       = 1'b1;
            dec_res.reply_target_mac = req_ff.sender_mac;
            dec_res.reply_target_ip  = req_ff.query_ip;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sweep_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = dec_upd ? ST_UPDATE : ST_OUT;
         end
         ST_UPDATE: begin
            if (sweep_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_if.ready = 1'b0;
      issue        = 1'b0;
      ram_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ST_SCAN: begin
            issue = (cnt_ff < CNT_END);
         end
         ST_UPDATE: begin
            issue  = (cnt_ff < CNT_END);
            ram_we = pend_ff;
         end
         ST_DECIDE, ST_OUT: begin
            issue = 1'b0;
         end
         default: issue = 1'b0;
      endcase
   end

   assign ram_rd_addr = cnt_ff[IDX_W-1:0];

   // datapath next values
   always_comb begin
      cnt_in       = cnt_ff;
      pend_in      = issue;
      pend_idx_in  = cnt_ff[IDX_W-1:0];
      valid_in     = valid_ff;
      rank_init_in = rank_init_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);
      my_ip_in     = my_ip_ff;
      req_in       = req_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_mac_in   = hit_mac_ff;
      lru_idx_in   = lru_idx_ff;
      lru_rank_in  = lru_rank_ff;
      tgt_in       = tgt_ff;
      tgt_rank_in  = tgt_rank_ff;
      wr_ip_in     = wr_ip_ff;
      wr_mac_in    = wr_mac_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_load ? res_ff : rsp_data_ff;

      // own address register
      if (csr_we && (csr_idx == CSR_MY_IP)) begin
         my_ip_in = csr_wdata[IP_W-1:0];
      end

      // sweep counter
      if (req_xfer || (state_ff == ST_DECIDE)) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end

      // capture request
      if (req_xfer) begin
         req_in = req_if.data;
         hit_in = 1'b0;
      end

      // search sweep: best match and least recent entry
      if ((state_ff == ST_SCAN) && pend_ff) begin
         if (valid_ff[pend_idx_ff] && (rd_ip == req_ff.query_ip)
             && (!hit_ff || (rank_eff < hit_rank_ff))) begin
            hit_in      = 1'b1;
            hit_idx_in  = pend_idx_ff;
            hit_rank_in = rank_eff;
            hit_mac_in  = rd_mac;
         end
         if ((pend_idx_ff == '0) || (rank_eff > lru_rank_ff)) begin
            lru_idx_in  = pend_idx_ff;
            lru_rank_in = rank_eff;
         end
      end

      // latch decision
      if (state_ff == ST_DECIDE) begin
         tgt_in      = dec_tgt;
         tgt_rank_in = dec_rank;
         wr_ip_in    = dec_wr_ip;
         wr_mac_in   = dec_wr_mac;
         res_in      = dec_res;
      end

      // rank sweep: mark inserted entry, ranks live in ram afterwards
      if (ram_we && at_tgt && wr_ip_ff) begin
         valid_in[pend_idx_ff] = 1'b1;
      end
      if ((state_ff == ST_UPDATE) && sweep_done) begin
         rank_init_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rank_init_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         my_ip_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rank_init_ff <= rank_init_in;
         rsp_valid_ff <= rsp_valid_in;
         my_ip_ff     <= my_ip_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      hit_mac_ff  <= hit_mac_in;
      lru_idx_ff  <= lru_idx_in;
      lru_rank_ff <= lru_rank_in;
      tgt_ff      <= tgt_in;
      tgt_rank_ff <= tgt_rank_in;
      wr_ip_ff    <= wr_ip_in;
      wr_mac_ff   <= wr_mac_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // response channel
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // a reply is only requested for a well-formed packet
   a_reply_needs_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.data.send_reply) |-> rsp_if.data.frame_ok)
      else $error("reply requested for a malformed packet");

   // no mac is resolved without a hit
   a_mac_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.data.hit) |-> (rsp_if.data.resolved_mac == '0))
      else $error("resolved mac without hit");

   // entries never become invalid once filled
   a_valid_grows: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(valid_ff) & ~valid_ff) == '0))
      else $error("valid entry dropped");

   // ranks stay in ram once the first rank sweep is done
   a_rank_init_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(rank_init_ff))
      else $error("rank init flag dropped");

endmodule
